// ===== design/mfcd_pkg.sv =====
// Package for the framed CRC-16 deframer: result kinds, frame constants,
// the job record passed from front to back, and the CRC-16/XMODEM byte step.
// No dependencies.
`default_nettype none

package mfcd_pkg;

  localparam int unsigned FWD_OFFSET_DEF = 6;
  localparam int unsigned MAX_FWD_DEF    = 64;
  localparam int unsigned WIN_LEN        = 10;
  localparam int unsigned HDR_LEN        = 6;
  localparam int unsigned CNT_W          = 9;
  localparam int unsigned JQ_DEPTH       = 2;

  localparam logic [7:0]  SYNC0     = 8'h69;
  localparam logic [7:0]  SYNC1     = 8'hBF;
  localparam logic [7:0]  MARK0     = 8'h99;
  localparam logic [7:0]  MARK1     = 8'h79;
  localparam logic [7:0]  MIN_LEN   = 8'd4;
  localparam logic [2:0]  HDR_SKIP  = 3'd5;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_TOP   = 16'h8000;

  typedef enum logic [2:0] {
    KIND_FWD = 3'd0,
    KIND_DUP = 3'd1,
    KIND_CRC = 3'd2,
    KIND_HDR = 3'd3,
    KIND_BIG = 3'd4
  } kind_e;

  // A finished frame travels as KIND_FWD with its region length; every
  // other kind is a status result.
  typedef struct packed {
    kind_e            kind;
    logic [CNT_W-1:0] len;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/mfcd_front.sv =====
// Front part of the deframer: hunts for frame heads, tracks the frame body,
// runs the CRC, writes the frame store and queues one job per outcome.
// Depends on mfcd_pkg.
`default_nettype none

module mfcd_front #(
  parameter int unsigned FWD_OFFSET = mfcd_pkg::FWD_OFFSET_DEF,
  parameter int unsigned MAX_FWD    = mfcd_pkg::MAX_FWD_DEF,
  parameter int unsigned AW         = $clog2(MAX_FWD)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire logic [7:0]     rx_byte_i,
  output logic                full_o,
  input  wire logic           q_full_i,
  output logic                job_push_o,
  output mfcd_pkg::job_t      job_o,
  input  wire logic           done_i,
  output logic                st_we_o,
  output logic [AW-1:0]       st_addr_o,
  output logic [7:0]          st_data_o
);
  import mfcd_pkg::*;

  typedef enum logic [2:0] {
    FS_HUNT = 3'b001,
    FS_HEAD = 3'b010,
    FS_BODY = 3'b100
  } fstate_e;

  fstate_e          state_q, state_d;
  logic [7:0]       win_q [WIN_LEN];
  logic [7:0]       win_d [WIN_LEN];
  logic [7:0]       win_sh [WIN_LEN];
  logic [2:0]       sup_q, sup_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       len_q, len_d;
  logic [15:0]      crc_q, crc_d, crc_nx;
  logic [15:0]      exp_q, exp_d;
  logic [3:0]       k_q, k_d;
  logic             pend_q, pend_d;
  logic             accept, head_hit, hdr_bad, fin;
  logic [CNT_W-1:0] tot, reg_len, cnt_nx, idx;
  logic [3:0]       kdiff;
  kind_e            fin_kind;

  assign full_o = q_full_i || pend_q || (state_q == FS_HEAD);
  assign accept = push_i && !full_o;

  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win_sh[i] = win_q[i+1];
    end
    win_sh[WIN_LEN-1] = rx_byte_i;
  end

  assign head_hit = (sup_q == 3'd0) && (win_sh[0] == SYNC0) && (win_sh[1] == SYNC1) &&
                    (win_sh[8] == MARK0) && (win_sh[9] == MARK1);
  assign hdr_bad  = (win_sh[3] != 8'h00) || (win_sh[2] < MIN_LEN);

  assign crc_nx  = crc_byte(crc_q, (state_q == FS_HEAD) ? win_q[k_q] : rx_byte_i);
  assign tot     = {1'b0, len_q} + CNT_W'(HDR_LEN);
  assign reg_len = tot - CNT_W'(FWD_OFFSET);
  assign cnt_nx  = cnt_q + 1'b1;
  assign idx     = cnt_q - CNT_W'(FWD_OFFSET);
  assign kdiff   = k_q - 4'(FWD_OFFSET);

  always_comb begin
    if (crc_nx != exp_q) begin
      fin_kind = KIND_CRC;
    end else if (reg_len > CNT_W'(MAX_FWD)) begin
      fin_kind = KIND_BIG;
    end else begin
      fin_kind = KIND_FWD;
    end
  end

  always_comb begin
    state_d    = state_q;
    win_d      = win_q;
    sup_d      = sup_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    crc_d      = crc_q;
    exp_d      = exp_q;
    k_d        = k_q;
    pend_d     = pend_q;
    fin        = 1'b0;
    job_push_o = 1'b0;
    job_o      = '{kind: KIND_HDR, len: reg_len};
    st_we_o    = 1'b0;
    st_addr_o  = '0;
    st_data_o  = '0;
    if (done_i) begin
      pend_d = 1'b0;
    end
    case (state_q)
      FS_HUNT: begin
        if (accept) begin
          win_d = win_sh;
          if (sup_q != 3'd0) begin
            sup_d = sup_q - 3'd1;
          end else if (head_hit) begin
            if (hdr_bad) begin
              sup_d      = HDR_SKIP;
              job_push_o = 1'b1;
            end else begin
              len_d   = win_sh[2];
              exp_d   = {win_sh[5], win_sh[4]};
              crc_d   = 16'h0000;
              k_d     = 4'd0;
              state_d = FS_HEAD;
            end
          end
        end
      end
      FS_HEAD: begin
        // One window byte per cycle: bytes from FWD_OFFSET on go into the store, bytes past HDR_LEN into the CRC.
        if (k_q >= 4'(FWD_OFFSET)) begin
          st_we_o   = 1'b1;
          st_addr_o = AW'(kdiff);
          st_data_o = win_q[k_q];
        end
        if (k_q >= 4'(HDR_LEN)) begin
          crc_d = crc_nx;
        end
        if (k_q == 4'(WIN_LEN - 1)) begin
          cnt_d = CNT_W'(WIN_LEN);
          if (tot <= CNT_W'(WIN_LEN)) begin
            fin = 1'b1;
          end else begin
            state_d = FS_BODY;
          end
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      FS_BODY: begin
        if (accept) begin
          crc_d = crc_nx;
          if ((cnt_q >= CNT_W'(FWD_OFFSET)) && (idx < CNT_W'(MAX_FWD))) begin
            st_we_o   = 1'b1;
            st_addr_o = idx[AW-1:0];
            st_data_o = rx_byte_i;
          end
          cnt_d = cnt_nx;
          if (cnt_nx >= tot) begin
            fin = 1'b1;
          end
        end
      end
      default: begin
        state_d = FS_HUNT;
      end
    endcase
    if (fin) begin
      state_d    = FS_HUNT;
      cnt_d      = '0;
      sup_d      = 3'd0;
      for (int i = 0; i < WIN_LEN; i++) begin
        win_d[i] = 8'h00;
      end
      job_push_o = 1'b1;
      job_o      = '{kind: fin_kind, len: reg_len};
      if (fin_kind == KIND_FWD) begin
        pend_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_HUNT;
      for (int i = 0; i < WIN_LEN; i++) begin
        win_q[i] <= 8'h00;
      end
      sup_q  <= 3'd0;
      cnt_q  <= '0;
      len_q  <= 8'h00;
      crc_q  <= 16'h0000;
      exp_q  <= 16'h0000;
      k_q    <= 4'd0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      win_q   <= win_d;
      sup_q   <= sup_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
      exp_q   <= exp_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
    end
  end

  // The store belongs to the back part while a frame job is outstanding.
  a_no_store_write_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !st_we_o) else $error("frame store written while a frame is pending");
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o |-> !q_full_i) else $error("job pushed into a full queue");
  a_head_len_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FS_HEAD) |-> (len_q >= MIN_LEN)) else $error("head taken with short length");

endmodule

`default_nettype wire

// ===== design/mfcd_jobq.sv =====
// Two-entry job queue between the front and back parts of the deframer.
// Depends on mfcd_pkg.
`default_nettype none

module mfcd_jobq (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  mfcd_pkg::job_t job_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output mfcd_pkg::job_t job_o,
  output logic           empty_o
);
  import mfcd_pkg::*;

  localparam int unsigned PW = $clog2(JQ_DEPTH);

  job_t              mem_q [JQ_DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [PW:0]       cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(JQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(JQ_DEPTH)) else $error("job queue count out of range");
  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("push not counted");
  a_cnt_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - 1'b1)) else $error("pop not counted");

endmodule

`default_nettype wire

// ===== design/mfcd_back.sv =====
// Back part of the deframer: holds the frame store and the previous region,
// compares them, emits forwarded bytes or a status result into the output
// register. Depends on mfcd_pkg.
`default_nettype none

module mfcd_back #(
  parameter int unsigned MAX_FWD = mfcd_pkg::MAX_FWD_DEF,
  parameter int unsigned AW      = $clog2(MAX_FWD)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  mfcd_pkg::job_t      job_i,
  output logic                q_pop_o,
  input  wire logic           st_we_i,
  input  wire logic [AW-1:0]  st_addr_i,
  input  wire logic [7:0]     st_data_i,
  output logic                done_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output logic [7:0]          out_byte_o,
  output logic [2:0]          out_kind_o,
  output logic                out_last_o
);
  import mfcd_pkg::*;

  typedef enum logic [5:0] {
    BS_IDLE    = 6'b000001,
    BS_CMP_RD  = 6'b000010,
    BS_CMP_CHK = 6'b000100,
    BS_EMIT_RD = 6'b001000,
    BS_EMIT_OUT= 6'b010000,
    BS_STAT    = 6'b100000
  } bstate_e;

  bstate_e          bst_q, bst_d;
  logic [CNT_W-1:0] i_q, i_d, n_q, n_d;
  kind_e            skind_q, skind_d;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       out_byte_q, out_byte_d;
  kind_e            out_kind_q, out_kind_d;
  logic             out_last_q, out_last_d;
  logic [MAX_FWD-1:0] prev_vld_q;
  logic [7:0]       store_mem [MAX_FWD];
  logic [7:0]       prev_mem  [MAX_FWD];
  logic [7:0]       store_rd_q, prev_rd_q, prev_eff;
  logic             pvld_rd_q, prev_we, out_free, last;
  logic [AW-1:0]    rd_addr;

  assign rd_addr  = i_q[AW-1:0];
  assign last     = (i_q == n_q - 1'b1);
  assign out_free = !out_vld_q || pop_i;
  // A previous-region entry never written still reads as zero.
  assign prev_eff = pvld_rd_q ? prev_rd_q : 8'h00;

  always_comb begin
    bst_d      = bst_q;
    i_d        = i_q;
    n_d        = n_q;
    skind_d    = skind_q;
    out_vld_d  = out_vld_q && !pop_i;
    out_byte_d = out_byte_q;
    out_kind_d = out_kind_q;
    out_last_d = out_last_q;
    q_pop_o    = 1'b0;
    done_o     = 1'b0;
    prev_we    = 1'b0;
    case (bst_q)
      BS_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          n_d     = job_i.len;
          i_d     = '0;
          skind_d = job_i.kind;
          bst_d   = (job_i.kind == KIND_FWD) ? BS_CMP_RD : BS_STAT;
        end
      end
      BS_CMP_RD: begin
        bst_d = BS_CMP_CHK;
      end
      BS_CMP_CHK: begin
        if (store_rd_q != prev_eff) begin
          i_d   = '0;
          bst_d = BS_EMIT_RD;
        end else if (last) begin
          skind_d = KIND_DUP;
          done_o  = 1'b1;
          bst_d   = BS_STAT;
        end else begin
          i_d   = i_q + 1'b1;
          bst_d = BS_CMP_RD;
        end
      end
      BS_EMIT_RD: begin
        bst_d = BS_EMIT_OUT;
      end
      BS_EMIT_OUT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_byte_d = store_rd_q;
          out_kind_d = KIND_FWD;
          out_last_d = last;
          prev_we    = 1'b1;
          if (last) begin
            done_o = 1'b1;
            bst_d  = BS_IDLE;
          end else begin
            i_d   = i_q + 1'b1;
            bst_d = BS_EMIT_RD;
          end
        end
      end
      BS_STAT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_byte_d = 8'h00;
          out_kind_d = skind_q;
          out_last_d = 1'b1;
          bst_d      = BS_IDLE;
        end
      end
      default: begin
        bst_d = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we_i) begin
      store_mem[st_addr_i] <= st_data_i;
    end
    if (prev_we) begin
      prev_mem[rd_addr] <= store_rd_q;
    end
    store_rd_q <= store_mem[rd_addr];
    prev_rd_q  <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_vld_q <= '0;
      pvld_rd_q  <= 1'b0;
      bst_q      <= BS_IDLE;
      i_q        <= '0;
      n_q        <= '0;
      skind_q    <= KIND_FWD;
      out_vld_q  <= 1'b0;
      out_byte_q <= 8'h00;
      out_kind_q <= KIND_FWD;
      out_last_q <= 1'b0;
    end else begin
      if (prev_we) begin
        prev_vld_q[rd_addr] <= 1'b1;
      end
      pvld_rd_q  <= prev_vld_q[rd_addr];
      bst_q      <= bst_d;
      i_q        <= i_d;
      n_q        <= n_d;
      skind_q    <= skind_d;
      out_vld_q  <= out_vld_d;
      out_byte_q <= out_byte_d;
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
    end
  end

  assign empty_o    = !out_vld_q;
  assign out_byte_o = out_byte_q;
  assign out_kind_o = out_kind_q;
  assign out_last_o = out_last_q;

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bst_q == BS_EMIT_OUT || bst_q == BS_CMP_CHK) |-> (i_q < n_q))
    else $error("region index beyond region length");
  a_status_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q != KIND_FWD) |-> (out_byte_q == 8'h00 && out_last_q))
    else $error("status result with byte or without last");
  a_no_store_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bst_q != BS_IDLE && bst_q != BS_STAT) |-> !st_we_i)
    else $error("frame store written during compare or emit");

endmodule

`default_nettype wire

// ===== design/magic_framed_crc16_deframer.sv =====
// Framed CRC-16 deframer, top level: front, job queue and back.
// Depends on mfcd_pkg, mfcd_front, mfcd_jobq and mfcd_back.
//
// Received bytes enter on push/full/rx_byte_i; results leave on empty/pop
// with out_byte_o, out_kind_o and out_last_o, the oldest result shown while
// empty is low. A byte that completes a valid frame head makes the front busy
// while the window bytes are stepped, one a cycle: those past the header into
// the CRC and those from the forward offset on into the frame store.
// Each frame outcome is queued as one job for the back part. A finished frame
// is compared with the previous region (one store read plus a check per byte;
// the walk stops at the first difference) and, if it differs, emitted with a
// store read and an output step per byte; the input stays blocked until that
// frame is fully handled, since the store is shared.
// With the back part idle, a header error, CRC error or oversize result leaves
// through the job queue and the back part's status state.
// Reset clears all control state and the valid bits of the previous region,
// which then reads as zero. A result not popped holds in the output register;
// the back part waits on it, and the front keeps taking bytes until the job
// queue fills or a frame is pending.
`default_nettype none

module magic_framed_crc16_deframer #(
  parameter int unsigned FWD_OFFSET = mfcd_pkg::FWD_OFFSET_DEF,
  parameter int unsigned MAX_FWD    = mfcd_pkg::MAX_FWD_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      out_kind_o,
  output logic            out_last_o
);
  import mfcd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FWD);

  logic          q_full, q_empty, q_push, q_pop, done, st_we;
  job_t          job_in, job_out;
  logic [AW-1:0] st_addr;
  logic [7:0]    st_data;

  mfcd_front #(
    .FWD_OFFSET (FWD_OFFSET),
    .MAX_FWD    (MAX_FWD),
    .AW         (AW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .q_full_i   (q_full),
    .job_push_o (q_push),
    .job_o      (job_in),
    .done_i     (done),
    .st_we_o    (st_we),
    .st_addr_o  (st_addr),
    .st_data_o  (st_data)
  );

  mfcd_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (job_out),
    .empty_o (q_empty)
  );

  mfcd_back #(
    .MAX_FWD (MAX_FWD),
    .AW      (AW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .job_i      (job_out),
    .q_pop_o    (q_pop),
    .st_we_i    (st_we),
    .st_addr_i  (st_addr),
    .st_data_i  (st_data),
    .done_o     (done),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .out_kind_o (out_kind_o),
    .out_last_o (out_last_o)
  );

endmodule

`default_nettype wire
